[src/dss_pkg.sv]
// ============================================================================
// dss_pkg
// Shared constants and types for the dual stack shared memory block.
// ============================================================================
package dss_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    // Stack operation codes carried in the request func field
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_LO = 3'd0,
        FN_PUSH_HI = 3'd1,
        FN_POP_LO  = 3'd2,
        FN_POP_HI  = 3'd3,
        FN_DUMP_LO = 3'd4,
        FN_DUMP_HI = 3'd5
    } func_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Controller sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_DUMP = 3'b100
    } state_t;

endpackage

[src/dss_if.sv]
// ============================================================================
// dss_if
// Valid/ready channels for stack requests and stack results.
// ============================================================================
interface dss_req_if import dss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface dss_rsp_if import dss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] word_out;
    logic [STAT_W-1:0]        status;
    logic                     last;

    modport source (output valid, output word_out, output status, output last, input ready);
    modport sink   (input valid, input word_out, input status, input last, output ready);
endinterface

[src/dual_stack_shared_memory_top.sv]
// ============================================================================
// dual_stack_shared_memory_top
// Two LIFO stacks sharing one RAM, one growing up, one growing down.
// ============================================================================
// Usage: each request transaction carries an operation (push, pop or dump on
// the low or the high stack) and a push word. A push writes the word when there
// is room and returns one result (ok, or full when the stacks meet). A pop
// reads the shared RAM, whose read data is registered, and returns the top
// word or an empty status. A dump of N words makes one RAM read per word and
// streams the words top first with last set on the final one; an empty
// stack dumps as a single empty result. Unused operation codes are dropped
// without a result. A new request is taken only when the sequencer is idle
// and the result register is free or being drained, so backpressure on the
// result channel stalls requests. The RAM contents are not cleared at reset;
// only the sequencer state, the two stack counts and the result valid are.
module dual_stack_shared_memory_top import dss_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    dss_req_if.sink   req,
    dss_rsp_if.source rsp
);

    // RAM port between the sequencer and the shared store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // Sequencer: stack counts, operation decode and result register
    dss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Shared store holding both stacks
    dss_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[src/dss_ram.sv]
// ============================================================================
// dss_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module dss_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/dss_ctrl.sv]
// ============================================================================
// dss_ctrl
// Stack sequencer: tracks both stack counts, drives the shared RAM and
// holds the result register.
// ============================================================================
module dss_ctrl import dss_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    dss_req_if.sink           req,
    dss_rsp_if.source         rsp,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [WORD_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [WORD_W-1:0] ram_rdata
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  low_cnt_reg, low_cnt_next;
    logic [CNT_W-1:0]  high_cnt_reg, high_cnt_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              up_reg, up_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    status_t           out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic              room;
    logic [CNT_W:0]    fill;
    logic [ADDR_W-1:0] low_top;
    logic [ADDR_W-1:0] high_top;
    logic [ADDR_W-1:0] high_free;
    logic [ADDR_W-1:0] step_ptr;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign fill      = {1'b0, low_cnt_reg} + {1'b0, high_cnt_reg};
    assign room      = fill < {1'b0, DEPTH_C};
    assign low_top   = ADDR_W'(low_cnt_reg - ONE_C);
    assign high_top  = ADDR_W'(DEPTH_C - high_cnt_reg);
    assign high_free = ADDR_W'(DEPTH_C - high_cnt_reg - ONE_C);
    assign step_ptr  = up_reg ? (ptr_reg + ADDR_W'(1)) : (ptr_reg - ADDR_W'(1));

    assign rsp.valid    = out_valid_reg;
    assign rsp.word_out = out_word_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.last     = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        low_cnt_next    = low_cnt_reg;
        high_cnt_next   = high_cnt_reg;
        remain_next     = remain_reg;
        ptr_next        = ptr_reg;
        up_next         = up_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_word_next   = out_word_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = low_cnt_reg[ADDR_W-1:0];
        ram_wdata       = req.push_value;
        ram_re          = 1'b0;
        ram_raddr       = low_top;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func_t'(req.func))
                        FN_PUSH_LO, FN_PUSH_HI:
                        begin
                            out_valid_next  = 1'b1;
                            out_word_next   = '0;
                            out_last_next   = 1'b1;
                            out_status_next = room ? STAT_OK : STAT_FULL;
                            if (room)
                            begin
                                ram_we = 1'b1;
                                if (func_t'(req.func) == FN_PUSH_LO)
                                begin
                                    ram_waddr    = low_cnt_reg[ADDR_W-1:0];
                                    low_cnt_next = low_cnt_reg + ONE_C;
                                end
                                else
                                begin
                                    ram_waddr     = high_free;
                                    high_cnt_next = high_cnt_reg + ONE_C;
                                end
                            end
                        end
                        FN_POP_LO:
                        begin
                            if (low_cnt_reg != '0)
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = low_top;
                                low_cnt_next = low_cnt_reg - ONE_C;
                                state_next   = ST_POP;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_word_next   = '0;
                                out_status_next = STAT_EMPTY;
                                out_last_next   = 1'b1;
                            end
                        end
                        FN_POP_HI:
                        begin
                            if (high_cnt_reg != '0)
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = high_top;
                                high_cnt_next = high_cnt_reg - ONE_C;
                                state_next    = ST_POP;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_word_next   = '0;
                                out_status_next = STAT_EMPTY;
                                out_last_next   = 1'b1;
                            end
                        end
                        FN_DUMP_LO:
                        begin
                            if (low_cnt_reg != '0)
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = low_top;
                                ptr_next    = low_top;
                                remain_next = low_cnt_reg;
                                up_next     = 1'b0;
                                state_next  = ST_DUMP;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_word_next   = '0;
                                out_status_next = STAT_EMPTY;
                                out_last_next   = 1'b1;
                            end
                        end
                        FN_DUMP_HI:
                        begin
                            if (high_cnt_reg != '0)
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = high_top;
                                ptr_next    = high_top;
                                remain_next = high_cnt_reg;
                                up_next     = 1'b1;
                                state_next  = ST_DUMP;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_word_next   = '0;
                                out_status_next = STAT_EMPTY;
                                out_last_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused codes: drop the transaction
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = ram_rdata;
                    out_status_next = STAT_OK;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = ram_rdata;
                    out_status_next = STAT_OK;
                    out_last_next   = (remain_reg == ONE_C);
                    if (remain_reg == ONE_C)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // advance to the next word of the stack
                        ram_re      = 1'b1;
                        ram_raddr   = step_ptr;
                        ptr_next    = step_ptr;
                        remain_next = remain_reg - ONE_C;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            low_cnt_reg   <= '0;
            high_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_cnt_reg   <= low_cnt_next;
            high_cnt_reg  <= high_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg     <= remain_next;
        ptr_reg        <= ptr_next;
        up_reg         <= up_next;
        out_word_reg   <= out_word_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule
